@@ rtl/bna_pkg.sv @@
// Package for the bitmap node allocator: field widths, codes, state type,
// the bit-find result struct and a mask helper.
// No dependencies; every other file of the block but bna_ram imports it.
`default_nettype none

package bna_pkg;

  // Field widths of the channels.
  localparam int MODE_W     = 2;
  localparam int NODE_IDX_W = 12;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 13;

  // Bitmap word geometry.
  localparam int WORD_W = 16;
  localparam int BIT_W  = 4;

  localparam logic [WORD_W-1:0]  FULL_WORD        = 16'hFFFF;
  localparam logic [WORD_W-1:0]  TOP_BIT          = 16'h8000;
  localparam logic [BIT_W-1:0]   BIT_IN_WORD_MASK = 4'hF;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET      = 13'd4096;
  localparam int                 MAX_NODES_DEF    = 4096;

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_MARK  = 2'd2
  } mode_e_t;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  // First clear bit of a bitmap word, counted from the top bit.
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } find_t;

  // Mask of one slot within its word; slot 0 is the most significant bit.
  function automatic logic [WORD_W-1:0] bit_mask(input logic [BIT_W-1:0] pos);
    bit_mask = TOP_BIT >> pos;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bna_ifs.sv @@
// Channel interfaces of the bitmap node allocator: request, result and
// configuration write. Depends on bna_pkg for the field widths.
`default_nettype none

// Request channel: one item asks for an allocate, free or mark-used.
interface bna_in_if import bna_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [NODE_IDX_W-1:0] node_index;

  modport source (output valid, mode, node_index, input ready);
  modport sink   (input valid, mode, node_index, output ready);
endinterface

// Result channel: one item per request.
interface bna_out_if import bna_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [NODE_IDX_W-1:0] node_number;

  modport source (output valid, status, node_number, input ready);
  modport sink   (input valid, status, node_number, output ready);
endinterface

// Configuration write channel for the slot count register.
interface bna_cfg_if import bna_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_nodes;

  modport source (output valid, total_nodes, input ready);
  modport sink   (input valid, total_nodes, output ready);
endinterface

`default_nettype wire

@@ rtl/bitmap_node_allocator.sv @@
// Top level of the bitmap node allocator: sequencer, bitmap RAM and the
// word search. Depends on bna_pkg, bna_ifs, bna_ram and bna_bit_find.
//
//   Channel  Dir  Handshake     Payload
//   in_ch    in   valid/ready   mode, node_index
//   out_ch   out  valid/ready   status, node_number
//   cfg_ch   in   valid/ready   total_nodes (always ready)
//
// Allocate holds the input while it tests the bitmap words in order, up to
// and including the first word with a clear bit or the last word of the slot
// range; it issues one RAM read a cycle through the single read port, after
// a first read that primes the test.
// Free and mark-used go through read, modify-write and result; a rejected
// index or the unused code goes from accept straight to result.
// After reset a clearing pass writes zeros over all (MAX_NODES + 15) / 16
// words, one a cycle, before the first request is taken.
// The finished item sits in the output register, so a stalled consumer only
// holds the sequencer once a second result is ready.
`default_nettype none

module bitmap_node_allocator import bna_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bna_in_if.sink     in_ch,
  bna_out_if.source  out_ch,
  bna_cfg_if.sink    cfg_ch
);

  localparam int MAP_WORDS = (MAX_NODES + WORD_W - 1) / WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW        = AW + BIT_W;
  localparam int CW        = ((IW > TOTAL_W) ? IW : TOTAL_W) + 1;

  localparam logic [CW-1:0] MAX_SLOTS = CW'(MAX_NODES);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  state_t                state_r, state_nxt;
  logic [TOTAL_W-1:0]    total_r;
  logic [AW-1:0]         scan_addr_r, scan_addr_nxt;
  logic [AW-1:0]         word_r, word_nxt;
  logic                  chk_valid_r, chk_valid_nxt;
  logic                  mark_r, mark_nxt;
  logic [BIT_W-1:0]      bsel_r, bsel_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [NODE_IDX_W-1:0] res_num_r, res_num_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [NODE_IDX_W-1:0] out_num_r, out_num_nxt;

  logic                  accept;
  logic                  out_free;
  logic [AW-1:0]         req_word;
  logic                  req_ok;
  logic                  req_upd;
  find_t                 find;
  logic [IW-1:0]         hit_idx;
  logic                  hit_ok;
  logic                  is_last;
  logic [CW-1:0]         next_base;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [WORD_W-1:0]     rd_data;

  // Bitmap storage.
  bna_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_bna_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Search over the word just read, used by the allocate scan.
  bna_bit_find u_bna_bit_find (
    .word (rd_data),
    .res  (find)
  );

  // Handshakes.
  assign in_ch.ready      = (state_r == ST_IDLE);
  assign accept           = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready     = 1'b1;
  assign out_free         = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.node_number = out_num_r;

  // Request decode: word of the slot and its range check.
  assign req_word = AW'(in_ch.node_index >> BIT_W);
  assign req_ok   = (CW'(in_ch.node_index) < CW'(total_r)) &&
                    (CW'(in_ch.node_index) < MAX_SLOTS);
  assign req_upd  = (mode_e_t'(in_ch.mode) == MODE_FREE) ||
                    (mode_e_t'(in_ch.mode) == MODE_MARK);

  // Scan check: slot found in the word under test, and end of the range.
  assign hit_idx   = {word_r, find.pos};
  assign hit_ok    = (CW'(hit_idx) < CW'(total_r)) && (CW'(hit_idx) < MAX_SLOTS);
  assign next_base = (CW'(word_r) + CW'(1)) << BIT_W;
  assign is_last   = (word_r == LAST_WORD) || (next_base >= CW'(total_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (scan_addr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (mode_e_t'(in_ch.mode) == MODE_ALLOC) begin
            state_nxt = ST_SCAN;
          end else if (req_upd && req_ok) begin
            state_nxt = ST_UPDATE;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (chk_valid_r && (find.hit || is_last)) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // RAM control and datapath registers.
  always_comb begin
    scan_addr_nxt  = scan_addr_r;
    word_nxt       = word_r;
    chk_valid_nxt  = chk_valid_r;
    mark_nxt       = mark_r;
    bsel_nxt       = bsel_r;
    res_status_nxt = res_status_r;
    res_num_nxt    = res_num_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_num_nxt    = out_num_r;
    wr_en          = 1'b0;
    wr_addr        = word_r;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = scan_addr_r;

    case (state_r)
      // Clearing pass: one zero word a cycle.
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = scan_addr_r;
        if (scan_addr_r == LAST_WORD) begin
          scan_addr_nxt = '0;
        end else begin
          scan_addr_nxt = scan_addr_r + AW'(1);
        end
      end
      // Take the item; free and mark-used read their word at once.
      ST_IDLE: begin
        rd_en   = accept;
        rd_addr = req_word;
        if (accept) begin
          word_nxt       = req_word;
          bsel_nxt       = BIT_W'(in_ch.node_index) & BIT_IN_WORD_MASK;
          mark_nxt       = (mode_e_t'(in_ch.mode) == MODE_MARK);
          scan_addr_nxt  = '0;
          chk_valid_nxt  = 1'b0;
          res_num_nxt    = '0;
          res_status_nxt = (req_upd && !req_ok) ? STATUS_RANGE : STATUS_OK;
        end
      end
      // Word scan: issue one read a cycle, test the word read last cycle.
      ST_SCAN: begin
        rd_en         = 1'b1;
        word_nxt      = scan_addr_r;
        chk_valid_nxt = 1'b1;
        if (scan_addr_r != LAST_WORD) begin
          scan_addr_nxt = scan_addr_r + AW'(1);
        end
        if (chk_valid_r) begin
          word_nxt = word_r;
          if (find.hit) begin
            if (hit_ok) begin
              wr_en          = 1'b1;
              wr_addr        = word_r;
              wr_data        = rd_data | bit_mask(find.pos);
              res_status_nxt = STATUS_OK;
              res_num_nxt    = NODE_IDX_W'(hit_idx);
            end else begin
              res_status_nxt = STATUS_FULL;
            end
          end else if (is_last) begin
            res_status_nxt = STATUS_FULL;
          end else begin
            word_nxt = scan_addr_r;
          end
        end
      end
      // Read-modify-write of one slot bit.
      ST_UPDATE: begin
        wr_en   = 1'b1;
        wr_addr = word_r;
        if (mark_r) begin
          wr_data = rd_data | bit_mask(bsel_r);
        end else begin
          wr_data = rd_data & ~bit_mask(bsel_r);
        end
      end
      // Hand the result to the output register.
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_num_nxt    = res_num_r;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_addr_r <= '0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= TOTAL_RESET;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        total_r <= cfg_ch.total_nodes;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    mark_r       <= mark_nxt;
    bsel_r       <= bsel_nxt;
    res_status_r <= res_status_nxt;
    res_num_r    <= res_num_nxt;
    out_status_r <= out_status_nxt;
    out_num_r    <= out_num_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/bna_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bna_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  rd_addr,
  output      logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bna_bit_find.sv @@
// Finds the first clear bit of one bitmap word, searching from the top bit.
// Depends on bna_pkg for the word width and the find_t result struct.
`default_nettype none

module bna_bit_find import bna_pkg::*; (
  input  wire logic [WORD_W-1:0] word,
  output      find_t             res
);

  // Priority search from the most significant bit down.
  always_comb begin
    res.hit = (word != FULL_WORD);
    res.pos = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (!word[b]) begin
        res.pos = BIT_W'(WORD_W - 1 - b);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bna_checker.sv @@
// Port-level checks for the bitmap node allocator, bound to its top level.
// Depends on bna_pkg and bna_ifs.
`default_nettype none

module bna_checker import bna_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bna_in_if.sink     in_ch,
  bna_out_if.source  out_ch
);

  // One item at a time: the block is busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request channel ready right after an item was taken");

  // A failed item never carries a slot number.
  a_fail_number_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != STATUS_OK)) |-> (out_ch.node_number == '0))
    else $error("failed result carries a nonzero slot number");

  // No result appears in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !$rose(out_ch.valid))
    else $error("result appeared one cycle after the item was taken");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.status) && $stable(out_ch.node_number)))
    else $error("stalled result changed or dropped");

endmodule

bind bitmap_node_allocator bna_checker u_bna_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

@@ tb/bna_tb_pkg.sv @@
// Shared testbench constants for the bitmap node allocator bench.
// Depends on bna_pkg for the field widths and the default slot count.
`timescale 1ns / 1ps

package bna_tb_pkg;
  import bna_pkg::*;

  // Request code that the block must ignore.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Bitmap geometry for the default build of the block.
  localparam int NUM_SLOTS = MAX_NODES_DEF;
  localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
endpackage

@@ tb/bna_alloc_check.sv @@
// Watches the request, result and configuration channels of the allocator,
// keeps its own slot bitmap and compares every result in order.
// Depends on bna_pkg, bna_tb_pkg and the channel interfaces in bna_ifs.
`timescale 1ns / 1ps

module bna_alloc_check import bna_pkg::*, bna_tb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bna_in_if    req,
  bna_out_if   rsp,
  bna_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding,
  output int   checked_count,
  output int   full_count,
  output int   range_count
);

  typedef struct packed {
    status_t               status;
    logic [NODE_IDX_W-1:0] node_number;
  } slot_result_t;

  // Shadow of the usage bitmap; slot 0 of a word is its top bit.
  logic [WORD_W-1:0]  usage_map [NUM_WORDS];
  logic [TOTAL_W-1:0] slot_limit;
  slot_result_t       result_q [$];

  function automatic bit slot_in_range(input logic [NODE_IDX_W-1:0] idx);
    return (idx < slot_limit) && (idx < NUM_SLOTS);
  endfunction

  // Applies one request to the shadow bitmap and returns its result.
  function automatic slot_result_t predict_request(input logic [MODE_W-1:0] mode,
                                                   input logic [NODE_IDX_W-1:0] idx);
    slot_result_t res;
    int w;
    int b;
    int slot;
    res.status      = STATUS_OK;
    res.node_number = '0;
    case (mode)
      MODE_ALLOC: begin
        // First word with a clear bit, then its first clear bit from the top.
        w = 0;
        while (w < NUM_WORDS && usage_map[w] == FULL_WORD) w++;
        if (w == NUM_WORDS) begin
          res.status = STATUS_FULL;
        end else begin
          b = 0;
          while (b < WORD_W - 1 && usage_map[w][WORD_W-1-b]) b++;
          slot = w * WORD_W + b;
          if (slot >= slot_limit || slot >= NUM_SLOTS) begin
            res.status = STATUS_FULL;
          end else begin
            usage_map[w][WORD_W-1-b] = 1'b1;
            res.node_number = slot[NODE_IDX_W-1:0];
          end
        end
      end
      MODE_FREE, MODE_MARK: begin
        if (!slot_in_range(idx)) begin
          res.status = STATUS_RANGE;
        end else begin
          usage_map[idx[NODE_IDX_W-1:BIT_W]][WORD_W-1-idx[BIT_W-1:0]] = (mode == MODE_MARK);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Results are compared before the same edge's request is predicted, since
  // a result can never belong to a request accepted at that very edge.
  always @(posedge clk) begin : watch
    slot_result_t want;
    if (!rst_n) begin
      foreach (usage_map[i]) usage_map[i] = '0;
      slot_limit = TOTAL_RESET;
      result_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing pending: status %0d node_number %0d",
                     $realtime, rsp.status, rsp.node_number);
        end else begin
          want = result_q.pop_front();
          checked_count++;
          if (want.status == STATUS_FULL) full_count++;
          if (want.status == STATUS_RANGE) range_count++;
          if (rsp.status !== want.status || rsp.node_number !== want.node_number) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: status exp %0d got %0d, node_number exp %0d got %0d",
                       $realtime, want.status, rsp.status, want.node_number,
                       rsp.node_number);
          end
        end
      end
      if (cfg.valid && cfg.ready) slot_limit = cfg.total_nodes;
      if (req.valid && req.ready)
        result_q.push_back(predict_request(req.mode, req.node_index));
    end
    outstanding <= result_q.size();
  end

endmodule

@@ tb/tb.sv @@
// Top of the allocator bench: clock, reset, request and slot-count stimulus,
// result back-pressure and the verdict. Depends on bna_pkg, bna_tb_pkg,
// bna_ifs, bna_alloc_check and the bitmap_node_allocator RTL.
`timescale 1ns / 1ps

module tb;
  import bna_pkg::*;
  import bna_tb_pkg::*;

  // Slot count of the closing phase, whose whole range is filled.
  localparam int FILL_SLOTS = 64;

  logic clk;
  logic rst_n;

  bna_in_if  in_ch ();
  bna_out_if out_ch ();
  bna_cfg_if cfg_ch ();

  int fail_count;
  int outstanding;
  int checked_count;
  int full_count;
  int range_count;
  int request_count;
  int setting_count;

  // When set, neither side inserts idle cycles.
  bit                 gapless;
  logic [TOTAL_W-1:0] slot_count;

  bitmap_node_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bna_alloc_check result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (in_ch),
    .rsp           (out_ch),
    .cfg           (cfg_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .full_count    (full_count),
    .range_count   (range_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL bitmap_node_allocator");
    $finish;
  end

  // Offers one request; returns at the falling edge after it was accepted,
  // with valid still high so a following request can go out back to back.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [NODE_IDX_W-1:0] idx);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.node_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    request_count++;
  endtask

  // Stops sending and waits until every pending result has come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_slot_count(input logic [TOTAL_W-1:0] n);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.total_nodes <= n;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    slot_count = n;
    setting_count++;
  endtask

  // Slot index for free or mark-used: mostly from zero up to the slot count,
  // including the first out-of-range index if it lies in the bitmap, sometimes anywhere.
  function automatic logic [NODE_IDX_W-1:0] pick_index();
    int lim;
    if ($urandom_range(0, 4) == 0) return NODE_IDX_W'($urandom_range(0, NUM_SLOTS - 1));
    lim = (slot_count >= NUM_SLOTS) ? NUM_SLOTS - 1 : int'(slot_count);
    return NODE_IDX_W'($urandom_range(0, lim));
  endfunction

  // Result side back-pressure: a random stall after each item.
  initial begin : result_drain
    int stall;
    out_ch.ready = 1'b1;
    @(negedge clk);
    forever begin
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
      stall = gapless ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int fill_order [FILL_SLOTS];
    int random_sent;
    int n_items;
    int sel;
    int pick;
    int j;
    int tmp;
    int spare;
    logic [TOTAL_W-1:0] n;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_ALLOC;
    in_ch.node_index   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.total_nodes = TOTAL_RESET;
    slot_count         = TOTAL_RESET;
    gapless            = 1'b0;
    random_sent        = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset slot count: first-fit order, refree,
    // double free and double mark at the top slot, and the unused code.
    send_request(MODE_ALLOC, 12'hFFF);
    send_request(MODE_ALLOC, 12'h000);
    send_request(MODE_FREE, 12'd0);
    send_request(MODE_ALLOC, 12'h555);
    send_request(MODE_MARK, 12'd4095);
    send_request(MODE_MARK, 12'd4095);
    send_request(MODE_FREE, 12'd4095);
    send_request(MODE_FREE, 12'd4095);
    send_request(MODE_UNUSED, 12'd4095);
    send_request(MODE_MARK, 12'd2);
    send_request(MODE_ALLOC, 12'hAAA);

    // No slots at all: allocate is full, free and mark are out of range.
    wait_idle();
    write_slot_count('0);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_FREE, 12'd0);
    send_request(MODE_MARK, 12'd0);

    // Slot count larger than the bitmap itself.
    wait_idle();
    write_slot_count({TOTAL_W{1'b1}});
    send_request(MODE_MARK, 12'd4095);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_FREE, 12'd4095);

    // First clear bit at the slot count: allocate fails, then frees a hole.
    wait_idle();
    write_slot_count(13'd5);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_FREE, 12'd5);
    send_request(MODE_MARK, 12'd4);
    send_request(MODE_FREE, 12'd1);
    send_request(MODE_ALLOC, 12'd0);

    // Random phases, each under its own slot count.
    while (random_sent < 1200) begin
      wait_idle();
      sel = $urandom_range(0, 9);
      case (sel)
        0:       n = '0;
        1:       n = TOTAL_RESET;
        2:       n = TOTAL_W'($urandom_range(NUM_SLOTS + 1, (1 << TOTAL_W) - 1));
        7, 8:    n = TOTAL_W'($urandom_range(65, NUM_SLOTS));
        9:       n = TOTAL_W'($urandom_range(0, (1 << TOTAL_W) - 1));
        default: n = TOTAL_W'($urandom_range(1, 64));
      endcase
      write_slot_count(n);
      gapless = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(30, 90);
      repeat (n_items) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          send_request(MODE_ALLOC, NODE_IDX_W'($urandom_range(0, NUM_SLOTS - 1)));
        else if (pick < 72)
          send_request(MODE_FREE, pick_index());
        else if (pick < 90)
          send_request(MODE_MARK, pick_index());
        else if (pick < 95)
          send_request(MODE_UNUSED, NODE_IDX_W'($urandom_range(0, NUM_SLOTS - 1)));
        else
          send_request(MODE_W'($urandom_range(0, 3)),
                       NODE_IDX_W'($urandom_range(0, NUM_SLOTS - 1)));
        random_sent++;
      end
    end

    // Mark every slot of a small range in shuffled order so the range is
    // full, then open a single hole and allocate it.
    wait_idle();
    gapless = 1'b0;
    write_slot_count(TOTAL_W'(FILL_SLOTS));
    for (int i = 0; i < FILL_SLOTS; i++) fill_order[i] = i;
    for (int i = FILL_SLOTS - 1; i > 0; i--) begin
      j             = $urandom_range(0, i);
      tmp           = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    foreach (fill_order[i]) send_request(MODE_MARK, NODE_IDX_W'(fill_order[i]));
    send_request(MODE_ALLOC, 12'd0);
    spare = $urandom_range(0, FILL_SLOTS - 1);
    send_request(MODE_FREE, NODE_IDX_W'(spare));
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_ALLOC, 12'd0);

    wait_idle();
    repeat (20) @(negedge clk);

    $display("Sent %0d requests under %0d slot-count settings, ending on a full slot range.",
             request_count, setting_count);
    $display("Checked %0d results: %0d full, %0d out of range, %0d failures.",
             checked_count, full_count, range_count, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS bitmap_node_allocator");
    end else begin
      $display("FAIL bitmap_node_allocator");
    end
    $finish;
  end

endmodule
